FILE: src/ipv4p_pkg.sv
`timescale 1ns / 1ps

package ipv4p_pkg;

    localparam int SYMBOL_W  = 8;
    localparam int ADDRESS_W = 32;
    localparam int STATUS_W  = 3;
    localparam int OCTET_W   = 8;
    localparam int NUM_DOTS  = 3;

    localparam logic [SYMBOL_W-1:0] DOT_CHAR  = 8'h2E;
    localparam logic [SYMBOL_W-1:0] ZERO_CHAR = 8'h30;
    localparam logic [SYMBOL_W-1:0] NINE_CHAR = 8'h39;

    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [1:0]  MAX_DIGITS = 2'd3;
    localparam logic [1:0]  LAST_DOT   = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK                = 3'd0,
        ST_TOO_MANY_DIGITS   = 3'd1,
        ST_OVER_255          = 3'd2,
        ST_EMPTY_OCTET       = 3'd3,
        ST_TOO_MANY_DOTS     = 3'd4,
        ST_BAD_CHAR          = 3'd5,
        ST_TRAILING_OR_EMPTY = 3'd6,
        ST_DOT_COUNT         = 3'd7
    } status_t;

endpackage

FILE: src/ipv4p_if.sv
`timescale 1ns / 1ps

interface ipv4p_text_if;
    logic                              valid;
    logic                              ready;
    logic [ipv4p_pkg::SYMBOL_W-1:0]    symbol;
    logic                              end_of_text;

    modport source (output valid, output symbol, output end_of_text, input ready);
    modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

interface ipv4p_result_if;
    logic                              valid;
    logic                              ready;
    logic [ipv4p_pkg::ADDRESS_W-1:0]   address;
    logic [ipv4p_pkg::STATUS_W-1:0]    status;

    modport source (output valid, output address, output status, input ready);
    modport sink   (input valid, input address, input status, output ready);
endinterface

FILE: src/ipv4_dotted_decimal_parser.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                          Beat
// text      in   symbol[7:0], end_of_text         one character or the end marker
// result    out  address[31:0], status[2:0]       one per end marker
//
// One beat per cycle on text while text.ready is high.
// A character updates the parse state at the next edge. An end marker loads the
// result register at that edge, so result.valid rises once the end beat has passed
// the input register, unless a stalled result still holds the result register.
// The cost is one input register, a multiply-by-ten/add/compare, one result register.
// rst_n clears the parse state and both valid flags; the octet store is not reset.
// A stalled result holds its register; text keeps flowing until an end marker
// reaches the input register behind it, then text.ready drops.

module ipv4_dotted_decimal_parser (
    input  logic             clk,
    input  logic             rst_n,
    ipv4p_text_if.sink       text,
    ipv4p_result_if.source   result
);
    import ipv4p_pkg::*;

    // input register
    logic                 stage_valid_reg, stage_valid_next;
    logic [SYMBOL_W-1:0]  stage_symbol_reg;
    logic                 stage_end_reg;

    // parse state
    logic [OCTET_W-1:0]   octet_reg, octet_next;
    logic [1:0]           digits_reg, digits_next;
    logic [1:0]           dots_reg, dots_next;
    status_t              error_reg, error_next;
    logic [OCTET_W-1:0]   done_octet_reg [NUM_DOTS];
    logic                 done_we;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [ADDRESS_W-1:0] out_address_reg, out_address_next;
    status_t              out_status_reg, out_status_next;

    logic                 advance;
    logic                 take_in;
    logic                 is_digit;
    logic [11:0]          scaled;
    status_t              end_status;

    assign advance = stage_valid_reg
                     && (!stage_end_reg || !out_valid_reg || result.ready);
    assign text.ready = !stage_valid_reg || advance;
    assign take_in    = text.valid && text.ready;

    assign result.valid   = out_valid_reg;
    assign result.address = out_address_reg;
    assign result.status  = out_status_reg;

    // octet*10 + digit, 12 bits holds up to 2559
    assign scaled = {1'b0, octet_reg, 3'b000} + {3'b000, octet_reg, 1'b0}
                    + {8'd0, stage_symbol_reg[3:0]};

    always_comb
    begin
        is_digit = stage_symbol_reg inside {[ZERO_CHAR:NINE_CHAR]};
    end

    always_comb
    begin
        if (error_reg != ST_OK)
            end_status = error_reg;
        else if (digits_reg == 2'd0)
            end_status = ST_TRAILING_OR_EMPTY;
        else if (dots_reg != LAST_DOT)
            end_status = ST_DOT_COUNT;
        else
            end_status = ST_OK;
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        octet_next       = octet_reg;
        digits_next      = digits_reg;
        dots_next        = dots_reg;
        error_next       = error_reg;
        done_we          = 1'b0;
        out_valid_next   = out_valid_reg;
        out_address_next = out_address_reg;
        out_status_next  = out_status_reg;

        if (result.ready)
            out_valid_next = 1'b0;

        if (advance)
        begin
            stage_valid_next = 1'b0;
            if (stage_end_reg)
            begin
                out_valid_next  = 1'b1;
                out_status_next = end_status;
                if (end_status == ST_OK)
                    out_address_next = {octet_reg, done_octet_reg[2],
                                        done_octet_reg[1], done_octet_reg[0]};
                else
                    out_address_next = '0;
                octet_next  = '0;
                digits_next = '0;
                dots_next   = '0;
                error_next  = ST_OK;
            end
            else if (error_reg == ST_OK)
            begin
                if (is_digit)
                begin
                    if (digits_reg >= MAX_DIGITS)
                        error_next = ST_TOO_MANY_DIGITS;
                    else if (scaled > OCTET_MAX)
                        error_next = ST_OVER_255;
                    else
                    begin
                        octet_next  = scaled[OCTET_W-1:0];
                        digits_next = digits_reg + 2'd1;
                    end
                end
                else if (stage_symbol_reg == DOT_CHAR)
                begin
                    if (digits_reg == 2'd0)
                        error_next = ST_EMPTY_OCTET;
                    else if (dots_reg >= LAST_DOT)
                        error_next = ST_TOO_MANY_DOTS;
                    else
                    begin
                        done_we     = 1'b1;
                        dots_next   = dots_reg + 2'd1;
                        octet_next  = '0;
                        digits_next = '0;
                    end
                end
                else
                begin
                    error_next = ST_BAD_CHAR;
                end
            end
        end

        if (take_in)
            stage_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            octet_reg       <= '0;
            digits_reg      <= '0;
            dots_reg        <= '0;
            error_reg       <= ST_OK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            octet_reg       <= octet_next;
            digits_reg      <= digits_next;
            dots_reg        <= dots_next;
            error_reg       <= error_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            stage_symbol_reg <= text.symbol;
            stage_end_reg    <= text.end_of_text;
        end
        if (done_we)
            done_octet_reg[dots_reg] <= octet_reg;
        out_address_reg <= out_address_next;
        out_status_reg  <= out_status_next;
    end

endmodule

FILE: src/ipv4p_checker.sv
`timescale 1ns / 1ps

module ipv4p_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                text_valid,
    input logic                                text_ready,
    input logic                                text_end_of_text,
    input logic                                result_valid,
    input logic                                result_ready,
    input logic [ipv4p_pkg::ADDRESS_W-1:0]     result_address,
    input logic [ipv4p_pkg::STATUS_W-1:0]      result_status
);
    import ipv4p_pkg::*;

    logic end_beat;
    assign end_beat = text_valid && text_ready && text_end_of_text;

    // an error result never carries an address
    a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_status != ST_OK) |-> result_address == '0)
        else $error("error result with nonzero address");

    // text only stalls behind a result that is itself stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |-> result_valid && !result_ready)
        else $error("text stalled without a waiting result");

    // a fresh result only follows an end marker
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(end_beat, 2))
        else $error("result without end marker");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_address) && $stable(result_status))
        else $error("stalled result changed");

endmodule

bind ipv4_dotted_decimal_parser ipv4p_checker u_ipv4p_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .text_valid       (text.valid),
    .text_ready       (text.ready),
    .text_end_of_text (text.end_of_text),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_address   (result.address),
    .result_status    (result.status)
);

FILE: tb/sv/tb_ipv4_dotted_decimal_parser.sv
`timescale 1ns / 1ps

module tb_ipv4_dotted_decimal_parser;

    import ipv4p_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int TOTAL_BEATS   = 1800;
    localparam int HOLD_AT_BEAT  = 600;
    localparam int DRAIN_AT_BEAT = 1100;
    localparam int CALM_FROM     = 1530;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_GAP       = 17;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int RADIX         = 10;

    // Predicts the parser result for each end marker and checks what comes out.
    class address_parse_checker;
        logic [OCTET_W-1:0]   cur_octet;
        logic [1:0]           cur_digits;
        logic [1:0]           dots_seen;
        logic [OCTET_W-1:0]   closed_octets [NUM_DOTS];
        status_t              first_fault;
        logic [ADDRESS_W-1:0] pending_address [$];
        status_t              pending_status [$];
        int                   texts;
        int                   results;
        int                   mismatches;
        int                   status_hits [8];

        function new();
            clear_parse();
            texts      = 0;
            results    = 0;
            mismatches = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        function void clear_parse();
            cur_octet  = '0;
            cur_digits = '0;
            dots_seen  = '0;
            foreach (closed_octets[i])
                closed_octets[i] = '0;
            first_fault = ST_OK;
        endfunction

        function void note_text(logic [SYMBOL_W-1:0] sym, logic eot);
            logic [11:0]          next_val;
            logic [ADDRESS_W-1:0] addr;
            status_t              st;
            if (eot) begin
                addr = '0;
                if (first_fault != ST_OK)
                    st = first_fault;
                else if (cur_digits == 2'd0)
                    st = ST_TRAILING_OR_EMPTY;
                else if (dots_seen != LAST_DOT)
                    st = ST_DOT_COUNT;
                else
                begin
                    st   = ST_OK;
                    addr = {cur_octet, closed_octets[2], closed_octets[1], closed_octets[0]};
                end
                pending_address.push_back(addr);
                pending_status.push_back(st);
                texts++;
                clear_parse();
            end
            else if (first_fault == ST_OK) begin
                if (sym >= ZERO_CHAR && sym <= NINE_CHAR) begin
                    next_val = 12'(cur_octet) * 12'(RADIX) + 12'(sym - ZERO_CHAR);
                    if (cur_digits >= MAX_DIGITS)
                        first_fault = ST_TOO_MANY_DIGITS;
                    else if (next_val > OCTET_MAX)
                        first_fault = ST_OVER_255;
                    else
                    begin
                        cur_octet  = next_val[OCTET_W-1:0];
                        cur_digits = cur_digits + 2'd1;
                    end
                end
                else if (sym == DOT_CHAR) begin
                    if (cur_digits == 2'd0)
                        first_fault = ST_EMPTY_OCTET;
                    else if (dots_seen >= LAST_DOT)
                        first_fault = ST_TOO_MANY_DOTS;
                    else
                    begin
                        closed_octets[dots_seen] = cur_octet;
                        dots_seen  = dots_seen + 2'd1;
                        cur_octet  = '0;
                        cur_digits = '0;
                    end
                end
                else
                begin
                    first_fault = ST_BAD_CHAR;
                end
            end
        endfunction

        function void flag(string what, logic [ADDRESS_W-1:0] want, logic [ADDRESS_W-1:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("MISMATCH %s on result %0d: expected 0x%08h, got 0x%08h",
                         what, results, want, got);
        endfunction

        function void check_result(logic [ADDRESS_W-1:0] addr, logic [STATUS_W-1:0] st);
            logic [ADDRESS_W-1:0] want_addr;
            status_t              want_st;
            results++;
            if (pending_address.size() == 0) begin
                flag("unexpected result", '0, addr);
            end
            else
            begin
                want_addr = pending_address.pop_front();
                want_st   = pending_status.pop_front();
                status_hits[want_st]++;
                if (addr !== want_addr)
                    flag("address", want_addr, addr);
                if (st !== want_st)
                    flag("status", ADDRESS_W'(want_st), ADDRESS_W'(st));
            end
        endfunction

        function int outstanding();
            return pending_address.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ipv4p_text_if   text_ch();
    ipv4p_result_if result_ch();

    address_parse_checker checker_h = new();

    int beats_sent = 0;
    bit calm       = 1'b0;
    bit hold_req   = 1'b0;

    ipv4_dotted_decimal_parser u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (text_ch.valid && text_ch.ready)
                checker_h.note_text(text_ch.symbol, text_ch.end_of_text);
            if (result_ch.valid && result_ch.ready)
                checker_h.check_result(result_ch.address, result_ch.status);
        end
    end

    // Result side back-pressure: random bursts, one long hold on request.
    initial begin : result_sink
        int n;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                result_ch.ready <= 1'b0;
                for (n = 0; n < LONG_HOLD; n++)
                    @(posedge clk);
                hold_req = 1'b0;
                result_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [SYMBOL_W-1:0] sym, input logic eot);
        if (!calm && $urandom_range(0, 9) == 0) begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.symbol      <= sym;
        text_ch.end_of_text <= eot;
        do
            @(posedge clk);
        while (!text_ch.ready);
        beats_sent++;
    endtask

    task automatic send_text(input logic [SYMBOL_W-1:0] chars[$], input logic [SYMBOL_W-1:0] end_sym);
        foreach (chars[i])
            send_beat(chars[i], 1'b0);
        send_beat(end_sym, 1'b1);
    endtask

    task automatic send_str(input string s, input logic [SYMBOL_W-1:0] end_sym);
        logic [SYMBOL_W-1:0] chars[$];
        for (int i = 0; i < s.len(); i++)
            chars.push_back(s[i]);
        send_text(chars, end_sym);
    endtask

    // Decimal digits of value, left padded with zeros to width.
    function automatic void push_number(ref logic [SYMBOL_W-1:0] chars[$],
                                        input int unsigned value, input int unsigned width);
        logic [SYMBOL_W-1:0] tmp[$];
        int unsigned         v;
        v = value;
        do
        begin
            tmp.push_front(ZERO_CHAR + SYMBOL_W'(v % RADIX));
            v = v / RADIX;
        end
        while (v != 0);
        while (tmp.size() < width)
            tmp.push_front(ZERO_CHAR);
        foreach (tmp[i])
            chars.push_back(tmp[i]);
    endfunction

    initial begin : stimulus
        logic [SYMBOL_W-1:0] chars[$];
        int                  mode;
        int                  n;
        int                  pos;
        int unsigned         value;
        bit                  hold_done;
        bit                  drain_done;
        int                  waited;

        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n               <= 1'b0;
        text_ch.valid       <= 1'b0;
        text_ch.symbol      <= '0;
        text_ch.end_of_text <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_str("0.0.0.0", 8'h00);
        send_str("255.255.255.255", 8'hFF);
        send_str("001.010.100.009", 8'h2E);      // leading zeros
        send_str("1.2.3.4", 8'h35);              // symbol on the end beat is ignored
        send_str("0000.1.1.1", 8'h30);           // fourth digit
        send_str("256.1.1.1", 8'h00);            // octet over 255
        send_str("1.2.3.999", 8'h00);
        send_str(".1.2.3", 8'h00);               // empty octet up front
        send_str("1..2.3", 8'h00);
        send_str("1.2.3.4.5", 8'h00);            // fourth dot
        send_str("1.2.3/4", 8'h00);              // neighbors of the digit range
        send_str("1.2.3:4", 8'h00);
        send_str("1-2.3.4", 8'h00);
        send_str("1.2.x.999.", 8'h00);           // only the first fault counts
        send_str("1.2.3.", 8'h00);               // trailing dot
        send_str("", 8'h41);                     // empty text
        send_str("1.2.3", 8'h00);                // dot count short
        chars = {8'h31, DOT_CHAR, 8'h00};
        send_text(chars, 8'h00);
        chars = {8'h31, DOT_CHAR, 8'hFF, 8'h80};
        send_text(chars, 8'h7F);

        while (beats_sent < TOTAL_BEATS) begin
            if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && beats_sent >= DRAIN_AT_BEAT) begin
                drain_done = 1'b1;
                text_ch.valid <= 1'b0;
                while (checker_h.outstanding() != 0)
                    @(posedge clk);
            end
            if (beats_sent >= CALM_FROM)
                calm = 1'b1;

            chars.delete();
            mode = $urandom_range(0, 15);
            if (mode < 11) begin
                // well-formed address, sometimes damaged in one spot
                for (int k = 0; k < 4; k++) begin
                    if (k != 0)
                        chars.push_back(DOT_CHAR);
                    case ($urandom_range(0, 7))
                        0:       value = 0;
                        1:       value = 255;
                        default: value = $urandom_range(0, 255);
                    endcase
                    push_number(chars, value,
                                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
                end
                if (mode >= 8) begin
                    pos = $urandom_range(0, chars.size() - 1);
                    case ($urandom_range(0, 5))
                        0: chars[pos] = SYMBOL_W'($urandom_range(0, 255));
                        1: chars.delete(pos);
                        2: chars.insert(pos, DOT_CHAR);
                        3: chars.insert(pos, ZERO_CHAR + SYMBOL_W'($urandom_range(0, 9)));
                        4: while (chars.size() > pos)
                               void'(chars.pop_back());
                        default:
                        begin
                            chars.push_back(DOT_CHAR);
                            push_number(chars, $urandom_range(0, 255), 0);
                        end
                    endcase
                end
            end
            else if (mode < 14) begin
                // wrong octet count, empty, long or oversized octets
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) begin
                    if (k != 0)
                        chars.push_back(DOT_CHAR);
                    if ($urandom_range(0, 5) != 0)
                        push_number(chars, $urandom_range(0, 999), $urandom_range(0, 4));
                end
            end
            else
            begin
                n = $urandom_range(0, 10);
                for (int k = 0; k < n; k++) begin
                    case ($urandom_range(0, 3))
                        0:       chars.push_back(DOT_CHAR);
                        1:       chars.push_back(ZERO_CHAR + SYMBOL_W'($urandom_range(0, 9)));
                        default: chars.push_back(SYMBOL_W'($urandom_range(0, 255)));
                    endcase
                end
            end
            send_text(chars, SYMBOL_W'($urandom_range(0, 255)));
        end
        text_ch.valid <= 1'b0;

        waited = 0;
        while (checker_h.outstanding() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (checker_h.outstanding() != 0) begin
            $display("Timed out with %0d results still pending", checker_h.outstanding());
            $display("Testbench completed WITH ERRORS");
        end
        else
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            $display("Sent %0d addresses in %0d beats; %0d results checked, %0d mismatches",
                     checker_h.texts, beats_sent, checker_h.results, checker_h.mismatches);
            $display("Status mix: ok %0d, digits %0d, over255 %0d, empty %0d, dots %0d, char %0d, trailing %0d, count %0d",
                     checker_h.status_hits[ST_OK], checker_h.status_hits[ST_TOO_MANY_DIGITS],
                     checker_h.status_hits[ST_OVER_255], checker_h.status_hits[ST_EMPTY_OCTET],
                     checker_h.status_hits[ST_TOO_MANY_DOTS], checker_h.status_hits[ST_BAD_CHAR],
                     checker_h.status_hits[ST_TRAILING_OR_EMPTY], checker_h.status_hits[ST_DOT_COUNT]);
            if (checker_h.mismatches == 0 && checker_h.outstanding() == 0)
                $display("Testbench completed without errors");
            else
                $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Run exceeded its time limit");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
src/ipv4p_pkg.sv
src/ipv4p_if.sv
src/ipv4_dotted_decimal_parser.sv
src/ipv4p_checker.sv
tb/sv/tb_ipv4_dotted_decimal_parser.sv
